/* hdl/roul_pkg.sv */
`timescale 1ns / 1ps

package roul_pkg;

  // Packed name: ten base-27 letters fit in 48 bits
  localparam int NAME_W = 48;

  // Opcodes carried on in_tuser
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // out_tuser bit positions
  localparam int TU_HAS_NAME   = 0;
  localparam int TU_OVERFLOWED = 1;
  localparam int OUT_TUSER_W   = 2;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } roul_state_t;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic              push;  // insert / move-to-front this cycle
    logic              pop;   // shift the row one place towards cell 0
    logic [NAME_W-1:0] name;  // name being pushed
  } roul_cell_ctl_t;

endpackage

/* hdl/recency_ordered_unique_list_core.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Ports                          | Word
// in_      | in  | tvalid tready tdata tuser      | tdata: name_code[47:0]; tuser: opcode
// out_     | out | tvalid tready tdata tlast tuser| tdata: name_out[47:0];
//          |     |                                | tuser: has_name[0], overflowed[1]
//
// Pushes are accepted back to back, the cell row matching and shifting in parallel
// at the accepting edge. A drain of N held names sends N words (one empty word for
// an empty list): while the output does not stall, one word leaves cell 0 per cycle
// as the row shifts forward; no input is accepted meanwhile.
// A stalled output holds the drain in place without losing a word.
// rst_n is synchronous, active low, and empties the list and clears the flag.

module recency_ordered_unique_list_core
  import roul_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [NAME_W-1:0]      in_tdata,   // name_code[47:0]
  input  logic                   in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [NAME_W-1:0]      out_tdata,  // name_out[47:0]
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser   // has_name[0], overflowed[1]
);

  roul_cell_ctl_t    ctl;
  logic [NAME_W-1:0] cell_name [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_valid;
  logic [LIST_DEPTH:0]   found;
  logic              ovf_set;

  assign found[0] = 1'b0;

  // Full and no match: the oldest entry drops off the end
  assign ovf_set = ctl.push && !found[LIST_DEPTH] && cell_valid[LIST_DEPTH-1];

  // Row of cells, cell 0 most recent
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [NAME_W-1:0] p_name, n_name;
    logic              p_valid, n_valid;

    if (i == 0) begin : g_head
      assign p_name  = ctl.name;
      assign p_valid = 1'b1;
    end else begin : g_mid
      assign p_name  = cell_name[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign n_name  = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_name  = cell_name[i+1];
      assign n_valid = cell_valid[i+1];
    end

    roul_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_name  (p_name),
      .prev_valid (p_valid),
      .next_name  (n_name),
      .next_valid (n_valid),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .name_q     (cell_name[i]),
      .valid_q    (cell_valid[i])
    );
  end

  roul_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .head_name    (cell_name[0]),
    .head_valid   (cell_valid[0]),
    .second_valid (cell_valid[1]),
    .ovf_set      (ovf_set),
    .ctl          (ctl)
  );

  // Valid cells always form a prefix from cell 0
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + {{(LIST_DEPTH-1){1'b0}}, 1'b1})) == '0)
    else $error("valid cells are not a prefix");

  // A word without a name only ever closes a drain
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[TU_HAS_NAME]) |-> out_tlast)
    else $error("empty word not marked last");

  // The row only shifts out when the output register can take the word
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (!out_tvalid || out_tready))
    else $error("pop while output word still pending");

endmodule

/* hdl/roul_cell.sv */
`timescale 1ns / 1ps

module roul_cell
  import roul_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  roul_cell_ctl_t    ctl,
  input  logic [NAME_W-1:0] prev_name,   // neighbour nearer the front
  input  logic              prev_valid,
  input  logic [NAME_W-1:0] next_name,   // neighbour nearer the back
  input  logic              next_valid,
  input  logic              found_in,    // a cell nearer the front matched
  output logic              found_out,
  output logic [NAME_W-1:0] name_q,
  output logic              valid_q
);

  logic [NAME_W-1:0] name_r, name_nxt;
  logic              valid_r, valid_nxt;
  logic              match;
  logic              take_prev;

  // Compare against the pushed name and pass the result down the row
  assign match     = valid_r && (name_r == ctl.name);
  assign found_out = found_in | match;

  // Shift back by one up to and including the matching cell, or the first free one
  assign take_prev = ctl.push && !found_in && prev_valid;

  always_comb begin
    name_nxt  = name_r;
    valid_nxt = valid_r;
    if (take_prev) begin
      name_nxt  = prev_name;
      valid_nxt = 1'b1;
    end else if (ctl.pop) begin
      name_nxt  = next_name;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r <= name_nxt;
  end

  assign name_q  = name_r;
  assign valid_q = valid_r;

endmodule

/* hdl/roul_ctrl.sv */
`timescale 1ns / 1ps

module roul_ctrl
  import roul_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [NAME_W-1:0]      in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [NAME_W-1:0]      out_tdata,
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic [NAME_W-1:0]      head_name,   // cell 0
  input  logic                   head_valid,
  input  logic                   second_valid, // cell 1
  input  logic                   ovf_set,      // push evicted the oldest entry
  output roul_cell_ctl_t         ctl
);

  roul_state_t       state_r, state_nxt;
  logic              in_fire;
  logic              drain_start;
  logic              emit;
  logic              final_word;

  logic              ovf_r, ovf_nxt;
  logic              ovf_snap_r, ovf_snap_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [NAME_W-1:0] out_name_r, out_name_nxt;
  logic              out_has_r, out_has_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  assign in_fire     = in_tvalid && in_tready;
  assign drain_start = in_fire && (in_tuser == OP_DRAIN);
  assign final_word  = !head_valid || !second_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (drain_start) state_nxt = ST_DRAIN;
      ST_DRAIN: if (emit && final_word) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_DRAIN: emit = !out_valid_r || out_tready;
      default:  in_tready = 1'b0;
    endcase
  end

  // Row control
  always_comb begin
    ctl.push = in_fire && (in_tuser == OP_PUSH);
    ctl.pop  = emit;
    ctl.name = in_tdata;
  end

  // Sticky overflow flag, snapshot taken when a drain starts
  always_comb begin
    ovf_nxt      = ovf_r;
    ovf_snap_nxt = ovf_snap_r;
    if (drain_start) begin
      ovf_snap_nxt = ovf_r;
      ovf_nxt      = 1'b0;
    end else if (ovf_set) begin
      ovf_nxt = 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_name_nxt  = out_name_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_name_nxt  = head_valid ? head_name : '0;
      out_has_nxt   = head_valid;
      out_last_nxt  = final_word;
      out_ovf_nxt   = ovf_snap_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_snap_r <= ovf_snap_nxt;
    out_name_r <= out_name_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid                = out_valid_r;
  assign out_tdata                 = out_name_r;
  assign out_tlast                 = out_last_r;
  assign out_tuser[TU_HAS_NAME]    = out_has_r;
  assign out_tuser[TU_OVERFLOWED]  = out_ovf_r;

  // A drain clears the sticky flag
  a_drain_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    drain_start |=> !ovf_r)
    else $error("overflow flag survived a drain");

  // The row never pushes and pops together
  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");

endmodule

/* tb/recency_ordered_unique_list_core_tb.sv */
`timescale 1ns / 1ps

module recency_ordered_unique_list_core_tb;
  import roul_pkg::*;

  localparam int DEPTH      = 64;
  localparam int ITEMS      = 330;
  localparam int QUIET_FROM = 150;     // no idling on either side in this window
  localparam int QUIET_TO   = 230;
  localparam int HOLD_AT    = 270;     // receiver hold-off starts here
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [NAME_W-1:0] MAX_PACKED = 48'd205891132094648;

  typedef struct {
    logic              op;
    logic [NAME_W-1:0] code;
  } list_cmd_t;

  typedef struct {
    logic [NAME_W-1:0] name;
    logic              has_name;
    logic              last;
    logic              overflowed;
  } drain_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [NAME_W-1:0] in_tdata = '0;
  logic in_tuser = OP_PUSH;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NAME_W-1:0] out_tdata;
  logic out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  list_cmd_t   pending_q[$];
  drain_word_t drain_words_q[$];
  int          total_items;
  int          accepted_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_cnt = 0;
  logic        hold_done = 1'b0;

  // Predicted list contents, slot 0 most recent
  logic [NAME_W-1:0] mtf_names[DEPTH];
  int                mtf_count = 0;
  logic              mtf_evicted = 1'b0;

  wire quiet_run = (accepted_cnt >= QUIET_FROM) && (accepted_cnt < QUIET_TO);

  recency_ordered_unique_list_core #(
    .LIST_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Move-to-front update for one accepted word; a drain queues its output words
  function automatic void mtf_apply(logic op, logic [NAME_W-1:0] code);
    int hit;
    int upto;
    drain_word_t w;
    if (op == OP_PUSH) begin
      hit = -1;
      for (int i = 0; i < mtf_count; i++) begin
        if (hit < 0 && mtf_names[i] == code) hit = i;
      end
      if (hit >= 0) begin
        upto = hit;
      end else if (mtf_count < DEPTH) begin
        upto = mtf_count;
        mtf_count++;
      end else begin
        // full: least recent entry drops off the end
        upto = DEPTH - 1;
        mtf_evicted = 1'b1;
      end
      for (int i = upto; i > 0; i--) mtf_names[i] = mtf_names[i-1];
      mtf_names[0] = code;
    end else begin
      if (mtf_count == 0) begin
        w.name = '0;
        w.has_name = 1'b0;
        w.last = 1'b1;
        w.overflowed = mtf_evicted;
        drain_words_q.push_back(w);
      end else begin
        for (int i = 0; i < mtf_count; i++) begin
          w.name = mtf_names[i];
          w.has_name = 1'b1;
          w.last = (i == mtf_count - 1);
          w.overflowed = mtf_evicted;
          drain_words_q.push_back(w);
        end
      end
      mtf_count = 0;
      mtf_evicted = 1'b0;
    end
  endfunction

  // Any 48-bit pattern, in or out of the packing range
  function automatic logic [NAME_W-1:0] raw_code();
    logic [NAME_W-1:0] c;
    c[31:0]  = $urandom();
    c[47:32] = 16'($urandom());
    return c;
  endfunction

  // Well-formed name: len letters then zero padding, first letter most significant
  function automatic logic [NAME_W-1:0] word_code(int len);
    logic [NAME_W-1:0] c;
    c = '0;
    for (int i = 0; i < 10; i++)
      c = c * 48'd27 + 48'((i < len) ? $urandom_range(26, 1) : 0);
    return c;
  endfunction

  function automatic logic [NAME_W-1:0] any_name();
    if ($urandom_range(99) < 80) return word_code($urandom_range(10, 1));
    return raw_code();
  endfunction

  task automatic add_push(logic [NAME_W-1:0] code);
    list_cmd_t c;
    c.op = OP_PUSH;
    c.code = code;
    pending_q.push_back(c);
  endtask

  // name field is ignored on a drain, so fill it with noise
  task automatic add_drain();
    list_cmd_t c;
    c.op = OP_DRAIN;
    c.code = raw_code();
    pending_q.push_back(c);
  endtask

  // Session that fills the list from empty, then optionally spills past it
  task automatic add_fill_session(int extra);
    logic [NAME_W-1:0] pool[DEPTH];
    add_drain();
    for (int i = 0; i < DEPTH; i++) begin
      pool[i] = any_name();
      add_push(pool[i]);
    end
    for (int i = 0; i < extra; i++) add_push(any_name());
    // revisit names from the fill; after a spill some of these are gone
    for (int i = 0; i < 6; i++) add_push(pool[$urandom_range(DEPTH - 1)]);
    add_drain();
  endtask

  task automatic add_short_session();
    logic [NAME_W-1:0] pool[8];
    int k;
    int n;
    k = $urandom_range(8, 1);
    n = $urandom_range(14, 1);
    for (int i = 0; i < k; i++) pool[i] = any_name();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) add_push(pool[$urandom_range(k - 1)]);
      else add_push(raw_code());
    end
    // now and then leave the list to run on into the next session
    if ($urandom_range(99) >= 10) add_drain();
    if ($urandom_range(99) < 10) add_drain();
  endtask

  // Stimulus, end of run
  initial begin
    int sess;
    // empty list, twice
    add_drain();
    add_drain();
    // extremes, codes out of range, interior zero digits, repeats
    add_push('0);
    add_push('1);
    add_push(MAX_PACKED);
    add_push(48'd1);
    add_push(48'hAAAA_AAAA_AAAA);
    add_push(48'h5555_5555_5555);
    add_push('0);
    add_push('1);
    add_push('1);
    add_drain();
    // single entry drain
    add_push(word_code(10));
    add_drain();
    add_drain();
    sess = 0;
    while (pending_q.size() < ITEMS) begin
      if (sess == 2) add_fill_session(0);
      else if (sess == 5) add_fill_session($urandom_range(10, 3));
      else add_short_session();
      sess++;
    end
    add_drain();
    total_items = pending_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_items) @(negedge clk);
    while (drain_words_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("recency_ordered_unique_list_core test passed");
    end else begin
      $display("recency_ordered_unique_list_core test failed");
    end
    $finish;
  end

  // Sender: holds a word until taken, idles at random outside the quiet window
  always @(posedge clk) begin : drv_proc
    list_cmd_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        mtf_apply(in_tuser, in_tdata);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && (quiet_run || $urandom_range(99) >= 10)) begin
          nxt = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tdata  <= nxt.code;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up a drain
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_run || ($urandom_range(99) >= 10);
    end
  end

  // Check each output word against the oldest prediction
  always @(posedge clk) begin : mon_proc
    drain_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (drain_words_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: unexpected word name=%h tuser=%b last=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        w = drain_words_q.pop_front();
        if (out_tdata !== w.name || out_tuser[TU_HAS_NAME] !== w.has_name ||
            out_tlast !== w.last || out_tuser[TU_OVERFLOWED] !== w.overflowed) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: exp name=%h has=%b last=%b ovf=%b, got name=%h has=%b last=%b ovf=%b",
                     w.name, w.has_name, w.last, w.overflowed, out_tdata,
                     out_tuser[TU_HAS_NAME], out_tlast, out_tuser[TU_OVERFLOWED]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("recency_ordered_unique_list_core test failed");
      $finish;
    end
  end

endmodule

/* recency_ordered_unique_list_core.f */
hdl/roul_pkg.sv
hdl/roul_cell.sv
hdl/roul_ctrl.sv
hdl/recency_ordered_unique_list_core.sv
tb/recency_ordered_unique_list_core_tb.sv
